[rtl/core/vcf_pkg.sv]
// Shared types, constants and the CRC-16/MODBUS byte update for the velocity command framer.
package vcf_pkg;

  localparam int unsigned VCF_QUEUE_DEPTH = 2;

  localparam int unsigned FRAME_LEN = 15;
  localparam int unsigned POS_W     = $clog2(FRAME_LEN);

  localparam logic [7:0]  SYNC_A_BYTE    = 8'hAA;
  localparam logic [7:0]  SYNC_B_BYTE    = 8'h55;
  localparam logic [7:0]  END_MARK_BYTE  = 8'hDD;
  localparam logic [7:0]  PAD_BYTE       = 8'h00;
  localparam logic [7:0]  DEV_ADDR_RESET = 8'h60;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  localparam logic [POS_W-1:0] POS_SYNC_A = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC_B = POS_W'(1);
  localparam logic [POS_W-1:0] POS_ADDR   = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LIN_HI = POS_W'(3);
  localparam logic [POS_W-1:0] POS_LIN_LO = POS_W'(4);
  localparam logic [POS_W-1:0] POS_ANG_HI = POS_W'(5);
  localparam logic [POS_W-1:0] POS_ANG_LO = POS_W'(6);
  localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(7);
  localparam logic [POS_W-1:0] POS_CRC_LO = POS_W'(8);
  localparam logic [POS_W-1:0] POS_END    = POS_W'(9);
  localparam logic [POS_W-1:0] POS_LAST   = POS_W'(FRAME_LEN - 1);

  typedef struct packed {
    logic signed [15:0] linear_speed;
    logic signed [15:0] angular_speed;
  } vcf_cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int b = 0; b < 8; b++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage

[rtl/core/velocity_command_framer_crc16.sv]
// Top level of the velocity command framer: address register, command queue and frame generator.
//
// Each request carries a signed linear and angular speed and is pushed on the in_ side
// while in_full is low. For every request the block emits a 15-byte command frame:
// 0xAA, 0x55, the device address, both speeds big-endian, the CRC-16/MODBUS of those
// seven bytes high byte first, the end marker 0xDD and five zero pad bytes. One byte
// is offered per result on the out_ side while out_empty is low; out_last_byte marks
// the fifteenth byte of a frame.
// A request is first registered in the queue; the first byte of its frame then goes through
// the output register. The frame generator produces one byte per cycle while the receiver
// keeps up, and frames follow each other without gaps. The command queue holds the frame being sent plus
// one more request, so the next request is accepted while the current frame is out.
// When the receiver stalls, the output register holds its byte, generation pauses and
// in_full rises once the queue fills. The cfg_ write channel is always ready and sets
// the device address used by every address byte produced after the write.
// Reset is synchronous: the queue and output are emptied and the address returns to 0x60.
module velocity_command_framer_crc16
  import vcf_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = VCF_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic signed [15:0] in_linear_speed,
  input  logic signed [15:0] in_angular_speed,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_frame_byte,
  output logic               out_last_byte,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_device_address
);

  logic [7:0] dev_addr_r;
  vcf_cmd_t   push_cmd;
  vcf_cmd_t   head_cmd;
  logic       head_valid;
  logic       head_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= DEV_ADDR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dev_addr_r <= cfg_device_address;
    end
  end

  assign push_cmd.linear_speed  = in_linear_speed;
  assign push_cmd.angular_speed = in_angular_speed;

  vcf_cmd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_push),
    .full       (in_full),
    .push_cmd   (push_cmd),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .head_take  (head_take)
  );

  vcf_frame_gen u_frame_gen (
    .clk            (clk),
    .rst_n          (rst_n),
    .device_address (dev_addr_r),
    .head_valid     (head_valid),
    .head_cmd       (head_cmd),
    .head_take      (head_take),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

[rtl/core/vcf_cmd_queue.sv]
// Front end: accepts speed commands and holds them in a short queue for the framer.
module vcf_cmd_queue
  import vcf_pkg::*;
#(
  parameter int unsigned DEPTH = VCF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  output logic     full,
  input  vcf_cmd_t push_cmd,
  output logic     head_valid,
  output vcf_cmd_t head_cmd,
  input  logic     head_take
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  vcf_cmd_t entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic do_push, do_take;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_take    = head_take && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_take) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_take) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_take && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

[rtl/core/vcf_frame_gen.sv]
// Back end: walks the queued command through the 15 frame bytes and updates the CRC.
module vcf_frame_gen
  import vcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] device_address,
  input  logic       head_valid,
  input  vcf_cmd_t   head_cmd,
  output logic       head_take,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r;
  logic             out_last_r;
  logic [7:0]       cur_byte;
  logic             emit;
  logic             at_last;

  assign emit      = head_valid && (!out_valid_r || out_pop);
  assign at_last   = (pos_r == POS_LAST);
  assign head_take = emit && at_last;

  always_comb begin
    unique case (pos_r)
      POS_SYNC_A: cur_byte = SYNC_A_BYTE;
      POS_SYNC_B: cur_byte = SYNC_B_BYTE;
      POS_ADDR:   cur_byte = device_address;
      POS_LIN_HI: cur_byte = head_cmd.linear_speed[15:8];
      POS_LIN_LO: cur_byte = head_cmd.linear_speed[7:0];
      POS_ANG_HI: cur_byte = head_cmd.angular_speed[15:8];
      POS_ANG_LO: cur_byte = head_cmd.angular_speed[7:0];
      POS_CRC_HI: cur_byte = crc_r[15:8];
      POS_CRC_LO: cur_byte = crc_r[7:0];
      POS_END:    cur_byte = END_MARK_BYTE;
      default:    cur_byte = PAD_BYTE;
    endcase
  end

  always_comb begin
    pos_nxt       = pos_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r;
    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (at_last) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r < POS_CRC_HI) begin
          crc_nxt = crc16_byte(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= cur_byte;
      out_last_r <= at_last;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_last_byte  = out_last_r;

  a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LAST)
    else $error("Frame position ran past the last byte.");

  a_pos_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !emit |=> $stable(pos_r))
    else $error("Frame position moved without a byte being produced.");

  a_last_is_pad: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && at_last) |=> (out_last_r && out_byte_r == PAD_BYTE && pos_r == POS_SYNC_A))
    else $error("Frame did not close with a flagged pad byte.");

  a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pos_r == POS_END) |=> (out_byte_r == END_MARK_BYTE && !out_last_r))
    else $error("End marker missing at its frame position.");

  a_crc_seed: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r == POS_SYNC_A) |-> (crc_r == CRC_INIT))
    else $error("CRC not seeded at the start of a frame.");

endmodule

[test/velocity_command_framer_crc16_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the velocity command framer: predicts and checks every frame byte.
module velocity_command_framer_crc16_test;
  import vcf_pkg::*;

  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned SETTLE       = 30;

  typedef struct {
    logic [7:0] value;
    logic       last;
  } frame_byte_t;

  logic               clk                = 1'b0;
  logic               rst_n              = 1'b0;
  logic               in_push            = 1'b0;
  logic               in_full;
  logic signed [15:0] in_linear_speed    = '0;
  logic signed [15:0] in_angular_speed   = '0;
  logic               out_empty;
  logic               out_pop            = 1'b0;
  logic [7:0]         out_frame_byte;
  logic               out_last_byte;
  logic               cfg_valid          = 1'b0;
  logic               cfg_ready;
  logic [7:0]         cfg_device_address = '0;

  vcf_cmd_t    commands_to_send[$];
  frame_byte_t frame_bytes_due[$];
  frame_byte_t oldest_due;
  logic [7:0]  address_reg    = DEV_ADDR_RESET;
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  logic        rx_hold        = 1'b0;
  int unsigned mismatch_count = 0;
  int unsigned quiet_cycles   = 0;

  velocity_command_framer_crc16 dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_push            (in_push),
    .in_full            (in_full),
    .in_linear_speed    (in_linear_speed),
    .in_angular_speed   (in_angular_speed),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_frame_byte     (out_frame_byte),
    .out_last_byte      (out_last_byte),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_device_address (cfg_device_address)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [15:0] modbus_crc(input logic [55:0] header);
    logic [15:0] acc;
    logic [7:0]  octet;
    acc = CRC_INIT;
    for (int i = 0; i < 7; i++) begin
      octet = header[55 - 8 * i -: 8];
      for (int b = 0; b < 8; b++) begin
        if (acc[0] ^ octet[b]) begin
          acc = (acc >> 1) ^ CRC_POLY;
        end else begin
          acc = acc >> 1;
        end
      end
    end
    return acc;
  endfunction

  function automatic void expect_frame(input vcf_cmd_t cmd);
    logic [55:0] header;
    logic [15:0] crc;
    header = {SYNC_A_BYTE, SYNC_B_BYTE, address_reg, cmd.linear_speed, cmd.angular_speed};
    crc = modbus_crc(header);
    for (int i = 0; i < 7; i++) begin
      frame_bytes_due.push_back('{header[55 - 8 * i -: 8], 1'b0});
    end
    frame_bytes_due.push_back('{crc[15:8], 1'b0});
    frame_bytes_due.push_back('{crc[7:0], 1'b0});
    frame_bytes_due.push_back('{END_MARK_BYTE, 1'b0});
    for (int k = 10; k < FRAME_LEN; k++) begin
      frame_bytes_due.push_back('{PAD_BYTE, k == FRAME_LEN - 1});
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        expect_frame(commands_to_send.pop_front());
      end
      if (!(in_push && in_full)) begin
        if (commands_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_push          <= 1'b1;
          in_linear_speed  <= commands_to_send[0].linear_speed;
          in_angular_speed <= commands_to_send[0].angular_speed;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (frame_bytes_due.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("unexpected frame byte %02h last %0b", out_frame_byte, out_last_byte);
          end
        end else begin
          oldest_due = frame_bytes_due.pop_front();
          if (out_frame_byte !== oldest_due.value || out_last_byte !== oldest_due.last) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
              $display("frame byte mismatch: expected %02h last %0b, got %02h last %0b",
                       oldest_due.value, oldest_due.last, out_frame_byte, out_last_byte);
            end
          end
        end
      end
      out_pop <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
    begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic queue_command(input logic [15:0] lin, input logic [15:0] ang);
    commands_to_send.push_back('{linear_speed: lin, angular_speed: ang});
  endtask

  task automatic send_random(input int unsigned count);
    @(negedge clk);
    repeat (count) queue_command(16'($urandom()), 16'($urandom()));
  endtask

  task automatic set_idling(input int unsigned tx_pct, input int unsigned rx_pct);
    @(negedge clk);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
  endtask

  task automatic write_address(input logic [7:0] addr);
    @(posedge clk);
    cfg_device_address <= addr;
    cfg_valid          <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid   <= 1'b0;
    address_reg = addr;
  endtask

  task automatic wait_drained();
    while (commands_to_send.size() != 0 || in_push || frame_bytes_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    queue_command(16'h0000, 16'h0000);
    queue_command(16'h8000, 16'h8000);
    queue_command(16'h7FFF, 16'h7FFF);
    queue_command(16'hFFFF, 16'hFFFF);
    queue_command(16'h7FFF, 16'h8000);
    queue_command(16'h8000, 16'h7FFF);
    queue_command(16'h0001, 16'hFFFF);
    queue_command(16'h00FF, 16'hFF00);
    queue_command(16'h5555, 16'hAAAA);
    queue_command(16'hAAAA, 16'h5555);
    queue_command(16'h0100, 16'h0080);
    wait_drained();

    write_address(8'hFF);
    set_idling(74, 0);
    send_random(40);
    wait_drained();

    write_address(8'h00);
    set_idling(0, 74);
    send_random(40);
    wait_drained();

    write_address(8'($urandom_range(1, 254)));
    set_idling(29, 29);
    send_random(40);
    wait_drained();

    write_address(8'($urandom_range(1, 254)));
    set_idling(0, 0);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (10) queue_command(16'($urandom()), 16'($urandom()));
    repeat (HOLD_CYCLES) @(negedge clk);
    rx_hold = 1'b0;
    send_random(20);
    wait_drained();

    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && frame_bytes_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[velocity_command_framer_crc16.f]
rtl/core/vcf_pkg.sv
rtl/core/vcf_cmd_queue.sv
rtl/core/vcf_frame_gen.sv
rtl/core/velocity_command_framer_crc16.sv
test/velocity_command_framer_crc16_test.sv
